FILE: rtl/core/ceg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ceg_pkg
// Shared types and constants of the correspondence-graph edge test.
// ----------------------------------------------------------------------------
package ceg_pkg;

  localparam int IDX_W      = 12;
  localparam int RES_W      = 16;
  localparam int DIST_W     = 21;
  localparam int GAP_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [DIST_W-1:0] RST_DELTA_DIST = 21'd256;
  localparam logic [DIST_W-1:0] RST_MAX_DIST   = {DIST_W{1'b1}};
  localparam logic [GAP_W-1:0]  RST_MAX_GAP    = {GAP_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_LOAD_X = 2'd0,
    FUNC_LOAD_Y = 2'd1,
    FUNC_TEST   = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 2'd0,
    CFG_DELTA_DIST = 2'd1,
    CFG_MAX_DIST   = 2'd2,
    CFG_MAX_GAP    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              mode;
    logic [DIST_W-1:0] delta_dist;
    logic [DIST_W-1:0] max_dist;
    logic [GAP_W-1:0]  max_gap;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/ceg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ceg_in_if / ceg_out_if
// Valid/ready channels for load and test items and for results.
// ----------------------------------------------------------------------------
interface ceg_in_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [11:0]                  atom_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic signed [15:0]           residue_number;
  logic [11:0]                  first_y_atom;
  logic [11:0]                  first_x_atom;
  logic [11:0]                  second_y_atom;
  logic [11:0]                  second_x_atom;

  modport source (
    output valid, func, atom_index, coord_x, coord_y, coord_z, residue_number,
           first_y_atom, first_x_atom, second_y_atom, second_x_atom,
    input  ready
  );
  modport sink (
    input  valid, func, atom_index, coord_x, coord_y, coord_z, residue_number,
           first_y_atom, first_x_atom, second_y_atom, second_x_atom,
    output ready
  );
endinterface

interface ceg_out_if;
  logic        valid;
  logic        ready;
  logic        is_edge;
  logic [20:0] dist_in_y;
  logic [20:0] dist_in_x;

  modport source (output valid, is_edge, dist_in_y, dist_in_x, input ready);
  modport sink (input valid, is_edge, dist_in_y, dist_in_x, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ceg_atom_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ceg_atom_mem
// Atom table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ceg_atom_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int WIDTH = 60
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr0_i,
  input  wire logic [AW-1:0]    raddr1_i,
  output logic      [WIDTH-1:0] rdata0_o,
  output logic      [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ceg_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ceg_isqrt
// Pipelined floor square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module ceg_isqrt #(
  parameter int SW     = 44,
  parameter int META_W = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [SW-1:0]       rad_i,
  input  wire logic [META_W-1:0]   meta_i,
  output logic                     valid_o,
  output logic      [SW/2-1:0]     root_o,
  output logic      [META_W-1:0]   meta_o
);

  localparam int RW = SW / 2;

  logic [RW+1:0]     rem_w  [RW+1];
  logic [RW-1:0]     root_w [RW+1];
  logic [SW-1:0]     rad_w  [RW+1];
  logic [META_W-1:0] meta_w [RW+1];
  logic              vld_w  [RW+1];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = rad_i;
  assign meta_w[0] = meta_i;
  assign vld_w[0]  = valid_i;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+1:0] rem_s;
    logic [RW+1:0] trial;
    logic          take;
    logic [RW+1:0] rem_q;
    logic [RW-1:0] root_q;
    logic [SW-1:0] rad_q;
    logic [META_W-1:0] meta_q;
    logic          vld_q;

    assign rem_s = {rem_w[i][RW-1:0], rad_w[i][SW-1 -: 2]};
    assign trial = {root_w[i], 2'b01};
    assign take  = rem_s >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? rem_s - trial : rem_s;
        root_q <= {root_w[i][RW-2:0], take};
        rad_q  <= {rad_w[i][SW-3:0], 2'b00};
        meta_q <= meta_w[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[i];
      end
    end

    assign rem_w[i+1]  = rem_q;
    assign root_w[i+1] = root_q;
    assign rad_w[i+1]  = rad_q;
    assign meta_w[i+1] = meta_q;
    assign vld_w[i+1]  = vld_q;
  end

  assign valid_o = vld_w[RW];
  assign root_o  = root_w[RW];
  assign meta_o  = meta_w[RW];

endmodule
`default_nettype wire

FILE: rtl/core/correspondence_graph_edge_test_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// correspondence_graph_edge_test_core
// Edge test between two correspondence-graph vertices over stored atom tables.
//
// in_ch carries load and test items, out_ch one result per item, both
// valid/ready; a transfer happens when valid and ready are both high.
// Loads (func 0/1) write the X or Y table entry and return all zeros.
// Tests (func 2) read both tables at two addresses each, square and sum
// the coordinate differences, take two floor square roots and compare.
// Pipeline: the table read, the squares, the sums, the root pipeline
// (one root bit per stage) and one output register, in that order.
// Throughput is one item per cycle while out_ch does not stall; the tables' two read ports serve
// both vertices of a test in the same cycle.
// A load is visible to a test accepted in the next cycle.
// When out_ch stalls the whole pipeline holds and in_ch.ready drops.
// Reset clears the pipeline valids and loads the register defaults;
// table contents are undefined until written.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i.
// ----------------------------------------------------------------------------
module correspondence_graph_edge_test_core import ceg_pkg::*; #(
  parameter int MAX_ATOMS  = 4096,
  parameter int COORD_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ceg_in_if.sink                     in_ch,
  ceg_out_if.source                  out_ch,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CB   = COORD_BITS;
  localparam int CW3  = 3 * CB;
  localparam int YW   = CW3 + RES_W;
  localparam int DW   = CB + 1;
  localparam int SQW  = 2 * DW;
  localparam int SW   = SQW + 2;
  localparam int RW   = SW / 2;
  localparam int CMPW = (RW > DIST_W) ? RW : DIST_W;

  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (r >= (32'(MAX_ATOMS) << k)) begin
        r = r - (32'(MAX_ATOMS) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= 1'b0;
      cfg_q.delta_dist <= RST_DELTA_DIST;
      cfg_q.max_dist   <= RST_MAX_DIST;
      cfg_q.max_gap    <= RST_MAX_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:       cfg_q.mode       <= cfg_data_i[0];
        CFG_DELTA_DIST: cfg_q.delta_dist <= cfg_data_i[DIST_W-1:0];
        CFG_MAX_DIST:   cfg_q.max_dist   <= cfg_data_i[DIST_W-1:0];
        CFG_MAX_GAP:    cfg_q.max_gap    <= cfg_data_i[GAP_W-1:0];
        default:        ;
      endcase
    end
  end

  // pipeline control
  logic  out_valid_q;
  logic  adv;
  logic  acc;
  func_e in_func;

  assign adv         = !out_valid_q || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;
  assign in_func     = func_e'(in_ch.func);

  logic [AW-1:0] wr_idx, y1_idx, x1_idx, y2_idx, x2_idx;

  assign wr_idx = wrap_idx(in_ch.atom_index);
  assign y1_idx = wrap_idx(in_ch.first_y_atom);
  assign x1_idx = wrap_idx(in_ch.first_x_atom);
  assign y2_idx = wrap_idx(in_ch.second_y_atom);
  assign x2_idx = wrap_idx(in_ch.second_x_atom);

  logic [CW3-1:0] xr0, xr1;
  logic [YW-1:0]  yr0, yr1;

  ceg_atom_mem #(.DEPTH(MAX_ATOMS), .AW(AW), .WIDTH(CW3)) u_xmem (
    .clk_i    (clk_i),
    .we_i     (acc && in_func == FUNC_LOAD_X),
    .waddr_i  (wr_idx),
    .wdata_i  ({in_ch.coord_z, in_ch.coord_y, in_ch.coord_x}),
    .re_i     (adv),
    .raddr0_i (x1_idx),
    .raddr1_i (x2_idx),
    .rdata0_o (xr0),
    .rdata1_o (xr1)
  );

  ceg_atom_mem #(.DEPTH(MAX_ATOMS), .AW(AW), .WIDTH(YW)) u_ymem (
    .clk_i    (clk_i),
    .we_i     (acc && in_func == FUNC_LOAD_Y),
    .waddr_i  (wr_idx),
    .wdata_i  ({in_ch.residue_number, in_ch.coord_z, in_ch.coord_y, in_ch.coord_x}),
    .re_i     (adv),
    .raddr0_i (y1_idx),
    .raddr1_i (y2_idx),
    .rdata0_o (yr0),
    .rdata1_o (yr1)
  );

  // stage 1: table read
  logic v1_q, t1_q, rep1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q   <= in_func == FUNC_TEST;
      rep1_q <= (y1_idx == y2_idx) || (x1_idx == x2_idx);
    end
  end

  // stage 2: squared differences, residue gap
  logic signed [DW-1:0] dy_c [3];
  logic signed [DW-1:0] dx_c [3];
  logic [DW-1:0]        my_c [3];
  logic [DW-1:0]        mx_c [3];
  logic signed [RES_W:0] g_c;
  logic [RES_W:0]        gm_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dy_c[k] = {yr0[k*CB+CB-1], yr0[k*CB +: CB]} - {yr1[k*CB+CB-1], yr1[k*CB +: CB]};
      dx_c[k] = {xr0[k*CB+CB-1], xr0[k*CB +: CB]} - {xr1[k*CB+CB-1], xr1[k*CB +: CB]};
      my_c[k] = dy_c[k][DW-1] ? DW'(-dy_c[k]) : DW'(dy_c[k]);
      mx_c[k] = dx_c[k][DW-1] ? DW'(-dx_c[k]) : DW'(dx_c[k]);
    end
    g_c  = {yr0[YW-1], yr0[CW3 +: RES_W]} - {yr1[YW-1], yr1[CW3 +: RES_W]};
    gm_c = g_c[RES_W] ? (RES_W+1)'(-g_c) : (RES_W+1)'(g_c);
  end

  logic             v2_q, t2_q, rep2_q;
  logic [SQW-1:0]   sqy_q [3];
  logic [SQW-1:0]   sqx_q [3];
  logic [RES_W:0]   gap2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sqy_q[k] <= my_c[k] * my_c[k];
        sqx_q[k] <= mx_c[k] * mx_c[k];
      end
      gap2_q <= gm_c;
      t2_q   <= t1_q;
      rep2_q <= rep1_q;
    end
  end

  // stage 3: sums of squares, repeat and residue gap check
  logic          v3_q, t3_q, okp3_q;
  logic [SW-1:0] sumy_q, sumx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sumy_q <= SW'(sqy_q[0]) + SW'(sqy_q[1]) + SW'(sqy_q[2]);
      sumx_q <= SW'(sqx_q[0]) + SW'(sqx_q[1]) + SW'(sqx_q[2]);
      t3_q   <= t2_q;
      okp3_q <= !rep2_q && (!cfg_q.mode || gap2_q <= {1'b0, cfg_q.max_gap});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_ch.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // square roots
  logic          y_vld, x_vld, y_okp, x_tst;
  logic [RW-1:0] root_y, root_x;

  ceg_isqrt #(.SW(SW), .META_W(1)) u_sqrt_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (sumy_q),
    .meta_i  (okp3_q),
    .valid_o (y_vld),
    .root_o  (root_y),
    .meta_o  (y_okp)
  );

  ceg_isqrt #(.SW(SW), .META_W(1)) u_sqrt_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (sumx_q),
    .meta_i  (t3_q),
    .valid_o (x_vld),
    .root_o  (root_x),
    .meta_o  (x_tst)
  );

  // output stage
  logic [CMPW-1:0]   dy_e, dx_e, dd_e;
  logic [DIST_W-1:0] saty, satx;
  logic              edge_c;

  always_comb begin
    dy_e   = CMPW'(root_y);
    dx_e   = CMPW'(root_x);
    dd_e   = (dy_e > dx_e) ? dy_e - dx_e : dx_e - dy_e;
    saty   = (dy_e > CMPW'(DIST_MAX)) ? DIST_MAX : dy_e[DIST_W-1:0];
    satx   = (dx_e > CMPW'(DIST_MAX)) ? DIST_MAX : dx_e[DIST_W-1:0];
    edge_c = x_tst && y_okp && dd_e <= CMPW'(cfg_q.delta_dist) &&
             (cfg_q.mode || (dy_e <= CMPW'(cfg_q.max_dist) &&
                             dx_e <= CMPW'(cfg_q.max_dist)));
  end

  logic              edge_q;
  logic [DIST_W-1:0] disty_q, distx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      edge_q  <= edge_c;
      disty_q <= x_tst ? saty : '0;
      distx_q <= x_tst ? satx : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= y_vld;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.is_edge   = edge_q;
  assign out_ch.dist_in_y = disty_q;
  assign out_ch.dist_in_x = distx_q;

  a_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_vld == x_vld) else $error("root lanes out of step");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> v1_q) else $error("transfer lost at table read");

  a_edge_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.is_edge && !cfg_q.mode |->
      out_ch.dist_in_y <= cfg_q.max_dist && out_ch.dist_in_x <= cfg_q.max_dist)
    else $error("edge beyond distance limit");

  a_edge_delta : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.is_edge |->
      ((out_ch.dist_in_y >= out_ch.dist_in_x) ?
        out_ch.dist_in_y - out_ch.dist_in_x :
        out_ch.dist_in_x - out_ch.dist_in_y) <= cfg_q.delta_dist)
    else $error("edge beyond tolerance");

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for correspondence_graph_edge_test_core. Loads fill the
// X/Y atom tables, test transfers are predicted with a local copy of the
// tables and registers (integer distances, tolerance, repeat and limit rules)
// and each result transfer is checked in order. Both channels idle in random
// bursts; once the result side stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import ceg_pkg::*;

  localparam int COORD_W   = 20;
  localparam int TABLE_N   = 4096;
  localparam int SETTLE    = 40;
  localparam int WATCH_MAX = 3000;
  localparam int HOLD_LEN  = 400;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                func;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic signed [RES_W-1:0]   res;
    logic [IDX_W-1:0]          y1, x1, y2, x2;
  } atom_item_t;

  typedef struct {
    logic              is_edge;
    logic [DIST_W-1:0] dy, dx;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ceg_in_if #(.COORD_BITS(COORD_W)) in_ch ();
  ceg_out_if out_ch ();

  correspondence_graph_edge_test_core #(
    .MAX_ATOMS (TABLE_N),
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  int x_tab [TABLE_N][3];
  int y_tab [TABLE_N][3];
  int y_res [TABLE_N];
  logic              m_mode;
  logic [DIST_W-1:0] m_delta, m_max_dist;
  logic [GAP_W-1:0]  m_max_gap;

  atom_item_t queued_items[$];
  verdict_t   pending_verdicts[$];
  int err_count   = 0;
  int in_accepts  = 0;
  int cycle_cnt   = 0;
  bit calm        = 1'b0;

  // generator bookkeeping
  bit   x_known [TABLE_N];
  bit   y_known [TABLE_N];
  int   x_list[$];
  int   y_list[$];

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned span(int a[3], int b[3]);
    longint unsigned acc;
    longint d;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'(a[k]) - longint'(b[k]);
      if (d < 0) d = -d;
      acc += longint'(d) * longint'(d);
    end
    return floor_root(acc);
  endfunction

  function automatic longint unsigned sat_dist(longint unsigned d);
    return (d > DIST_MAX) ? longint'(DIST_MAX) : d;
  endfunction

  task automatic apply_item(atom_item_t it);
    verdict_t v;
    longint unsigned dy, dx, diff, gap;
    longint g;
    bit ok;
    v = '{1'b0, '0, '0};
    case (it.func)
      FUNC_LOAD_X: begin
        x_tab[it.idx] = '{int'(it.cx), int'(it.cy), int'(it.cz)};
      end
      FUNC_LOAD_Y: begin
        y_tab[it.idx] = '{int'(it.cx), int'(it.cy), int'(it.cz)};
        y_res[it.idx] = int'(it.res);
      end
      FUNC_TEST: begin
        dy = span(y_tab[it.y1], y_tab[it.y2]);
        dx = span(x_tab[it.x1], x_tab[it.x2]);
        diff = (dy > dx) ? dy - dx : dx - dy;
        ok = diff <= m_delta && it.y1 != it.y2 && it.x1 != it.x2;
        if (m_mode == 1'b0) begin
          ok = ok && dy <= m_max_dist && dx <= m_max_dist;
        end else begin
          g = longint'(y_res[it.y1]) - longint'(y_res[it.y2]);
          gap = (g < 0) ? -g : g;
          ok = ok && gap <= m_max_gap;
        end
        v.is_edge = ok;
        v.dy = sat_dist(dy);
        v.dx = sat_dist(dx);
      end
      default: ;
    endcase
    pending_verdicts.insert(pending_verdicts.size(), v);
  endtask

  // driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= '0;
      in_ch.atom_index <= '0;
      in_ch.coord_x <= '0;
      in_ch.coord_y <= '0;
      in_ch.coord_z <= '0;
      in_ch.residue_number <= '0;
      in_ch.first_y_atom <= '0;
      in_ch.first_x_atom <= '0;
      in_ch.second_y_atom <= '0;
      in_ch.second_x_atom <= '0;
      send_gap = 0;
    end else begin
      atom_item_t it;
      if (in_ch.valid && in_ch.ready) begin
        apply_item('{in_ch.func, in_ch.atom_index, in_ch.coord_x, in_ch.coord_y,
                     in_ch.coord_z, in_ch.residue_number, in_ch.first_y_atom,
                     in_ch.first_x_atom, in_ch.second_y_atom, in_ch.second_x_atom});
        in_accepts++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap == 0 && !calm && (cycle_cnt / 300) % 3 != 0 &&
            $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 19);
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (queued_items.size() > 0) begin
          it = queued_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= it.func;
          in_ch.atom_index <= it.idx;
          in_ch.coord_x <= it.cx;
          in_ch.coord_y <= it.cy;
          in_ch.coord_z <= it.cz;
          in_ch.residue_number <= it.res;
          in_ch.first_y_atom <= it.y1;
          in_ch.first_x_atom <= it.x1;
          in_ch.second_y_atom <= it.y2;
          in_ch.second_x_atom <= it.x2;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  stall_left;
  bit  held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      held_once = 1'b0;
    end else begin
      verdict_t v;
      cycle_cnt++;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result transfer is_edge=%0b dy=%0d dx=%0d", $time,
                   out_ch.is_edge, out_ch.dist_in_y, out_ch.dist_in_x);
          err_count++;
        end else begin
          v = pending_verdicts.pop_front();
          if (out_ch.is_edge !== v.is_edge) begin
            $display("%0t: is_edge expected %0b actual %0b", $time, v.is_edge,
                     out_ch.is_edge);
            err_count++;
          end
          if (out_ch.dist_in_y !== v.dy) begin
            $display("%0t: dist_in_y expected %0d actual %0d", $time, v.dy,
                     out_ch.dist_in_y);
            err_count++;
          end
          if (out_ch.dist_in_x !== v.dx) begin
            $display("%0t: dist_in_x expected %0d actual %0d", $time, v.dx,
                     out_ch.dist_in_x);
            err_count++;
          end
        end
      end
      if (!held_once && in_accepts >= 120) begin
        held_once = 1'b1;
        stall_left = HOLD_LEN;
      end else if (stall_left == 0 && !calm && (cycle_cnt / 250) % 3 != 1 &&
                   $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  int quiet;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else if (quiet >= WATCH_MAX) begin
      $display("testbench: done, errors");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // stimulus helpers
  task automatic push_load(logic [1:0] f, int idx, int cx, int cy, int cz, int res);
    atom_item_t it;
    it = '{f, idx[IDX_W-1:0], cx[COORD_W-1:0], cy[COORD_W-1:0], cz[COORD_W-1:0],
           res[RES_W-1:0], 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)};
    queued_items.insert(queued_items.size(), it);
    if (f == FUNC_LOAD_X && !x_known[idx]) begin
      x_known[idx] = 1'b1;
      x_list.insert(x_list.size(), idx);
    end
    if (f == FUNC_LOAD_Y && !y_known[idx]) begin
      y_known[idx] = 1'b1;
      y_list.insert(y_list.size(), idx);
    end
  endtask

  task automatic push_test(logic [1:0] f, int y1, int x1, int y2, int x2);
    atom_item_t it;
    it = '{f, 12'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
           16'($urandom), y1[IDX_W-1:0], x1[IDX_W-1:0], y2[IDX_W-1:0], x2[IDX_W-1:0]};
    queued_items.insert(queued_items.size(), it);
  endtask

  function automatic int rnd_coord(bit wide);
    return wide ? int'($signed(20'($urandom))) : $urandom_range(0, 8000) - 4000;
  endfunction

  task automatic gen_random(int n);
    int r, a, b, c, d, bx, by, bz, rb;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_test(FUNC_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else if (r < 25) begin
        push_load(($urandom_range(0, 1) == 0) ? FUNC_LOAD_X : FUNC_LOAD_Y,
                  $urandom_range(0, 4095), rnd_coord(r < 12), rnd_coord(r < 12),
                  rnd_coord(r < 12), int'($signed(16'($urandom))));
      end else if (r < 60) begin
        // matched geometry: Y copies X with small noise, then test
        a = $urandom_range(0, 4095); b = $urandom_range(0, 4095);
        c = $urandom_range(0, 4095); d = $urandom_range(0, 4095);
        rb = $urandom_range(0, 60000) - 30000;
        bx = rnd_coord(0); by = rnd_coord(0); bz = rnd_coord(0);
        push_load(FUNC_LOAD_X, a, bx, by, bz, 0);
        push_load(FUNC_LOAD_Y, c, bx + $urandom_range(0, 128) - 64, by, bz, rb);
        bx = rnd_coord(0); by = rnd_coord(0); bz = rnd_coord(0);
        push_load(FUNC_LOAD_X, b, bx, by, bz, 0);
        push_load(FUNC_LOAD_Y, d, bx, by + $urandom_range(0, 512) - 256, bz,
                  rb + $urandom_range(0, 20) - 10);
        push_test(FUNC_TEST, c, a, d, b);
      end else begin
        push_test(FUNC_TEST, y_list[$urandom_range(0, y_list.size() - 1)],
                  x_list[$urandom_range(0, x_list.size() - 1)],
                  y_list[$urandom_range(0, y_list.size() - 1)],
                  x_list[$urandom_range(0, x_list.size() - 1)]);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (queued_items.size() != 0 || in_ch.valid || pending_verdicts.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_MODE:       m_mode = val[0];
      CFG_DELTA_DIST: m_delta = val;
      CFG_MAX_DIST:   m_max_dist = val;
      CFG_MAX_GAP:    m_max_gap = val[GAP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    m_mode = 1'b0;
    m_delta = RST_DELTA_DIST;
    m_max_dist = RST_MAX_DIST;
    m_max_gap = RST_MAX_GAP;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, repeats, unused code
    push_load(FUNC_LOAD_X, 0, 524287, 524287, 524287, 0);
    push_load(FUNC_LOAD_X, 4095, -524288, -524288, -524288, 0);
    push_load(FUNC_LOAD_Y, 0, -524288, -524288, -524288, 32767);
    push_load(FUNC_LOAD_Y, 4095, 524287, 524287, 524287, -32768);
    push_test(FUNC_TEST, 0, 0, 4095, 4095);
    push_test(FUNC_TEST, 0, 0, 0, 4095);
    push_test(FUNC_TEST, 0, 4095, 4095, 4095);
    push_test(FUNC_TEST, 4095, 4095, 4095, 4095);
    push_load(FUNC_LOAD_X, 1, 100, 0, 0, 0);
    push_load(FUNC_LOAD_X, 2, 356, 0, 0, 0);
    push_load(FUNC_LOAD_Y, 1, 0, 0, 0, 7);
    push_load(FUNC_LOAD_Y, 2, 0, 0, 256, 7);
    push_test(FUNC_TEST, 1, 1, 2, 2);
    push_load(FUNC_LOAD_Y, 2, 0, 0, 513, -5);
    push_test(FUNC_TEST, 1, 1, 2, 2);
    push_test(FUNC_TEST, 2, 2, 1, 1);
    push_test(FUNC_UNUSED, 1, 1, 2, 2);
    push_test(FUNC_TEST, 0, 1, 1, 4095);
    gen_random(100);
    wait_idle();

    write_reg(CFG_MODE, 1);
    write_reg(CFG_MAX_GAP, 8);
    write_reg(CFG_DELTA_DIST, 512);
    push_test(FUNC_TEST, 0, 0, 4095, 4095);
    gen_random(75);
    wait_idle();

    write_reg(CFG_MAX_GAP, 0);
    write_reg(CFG_DELTA_DIST, 0);
    gen_random(40);
    wait_idle();

    write_reg(CFG_MAX_GAP, 65535);
    write_reg(CFG_DELTA_DIST, 2097151);
    push_test(FUNC_TEST, 0, 0, 4095, 4095);
    gen_random(40);
    wait_idle();

    write_reg(CFG_MODE, 0);
    write_reg(CFG_MAX_DIST, 3000);
    gen_random(40);
    wait_idle();

    write_reg(CFG_MAX_DIST, 0);
    write_reg(CFG_DELTA_DIST, 100);
    gen_random(35);
    wait_idle();

    write_reg(CFG_MAX_DIST, 2097151);
    write_reg(CFG_DELTA_DIST, 256);
    calm = 1'b1;
    gen_random(55);
    wait_idle();

    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ceg_pkg.sv
rtl/core/ceg_if.sv
rtl/core/ceg_atom_mem.sv
rtl/core/ceg_isqrt.sv
rtl/core/correspondence_graph_edge_test_core.sv
test/testbench.sv
